// ===== hw/rtl/bblc_pkg.sv =====
// ----------------------------------------------------------------------------
// bblc_pkg: shared types and constants of the byte budget LRU cache
// Result kinds, default sizes and the front/back command record.
// ----------------------------------------------------------------------------
package bblc_pkg;

   localparam int unsigned ENTRIES_DEFAULT = 16;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam logic [31:0] CAP_RESET = 32'd268435456;

   typedef enum logic [1:0] {
      KIND_HIT     = 2'd0,
      KIND_INSERT  = 2'd1,
      KIND_EVICT   = 2'd2,
      KIND_TOO_BIG = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      BK_IDLE   = 2'd0,
      BK_SCAN   = 2'd1,
      BK_EMIT   = 2'd2
   } back_state_type;

   // Request record handed from front to back.
   typedef struct packed {
      logic [63:0] key;
      logic [31:0] size;
   } cmd_type;

endpackage

// ===== hw/rtl/bblc_req_if.sv =====
// ----------------------------------------------------------------------------
// bblc_req_if / bblc_rsp_if / bblc_csr_if: handshake channels
// Valid/ready channels for requests, results and capacity writes.
// ----------------------------------------------------------------------------
interface bblc_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] key;
   logic [31:0] object_size;
   modport source (output valid, output key, output object_size, input ready);
   modport sink (input valid, input key, input object_size, output ready);
endinterface

interface bblc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [63:0] result_key;
   logic [31:0] entry_size;
   logic [31:0] used_bytes;
   logic        last;
   modport source (output valid, output kind, output result_key, output entry_size,
                   output used_bytes, output last, input ready);
   modport sink (input valid, input kind, input result_key, input entry_size,
                 input used_bytes, input last, output ready);
endinterface

interface bblc_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bblc_front.sv =====
// ----------------------------------------------------------------------------
// bblc_front: request intake queue
// Accepts requests into a short queue that the back end drains.
// ----------------------------------------------------------------------------
module bblc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bblc_pkg::cmd_type    in_cmd,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bblc_pkg::cmd_type    out_cmd
);
   localparam int unsigned D = bblc_pkg::QUEUE_DEPTH;
   localparam int unsigned AW = (D > 1) ? $clog2(D) : 1;

   bblc_pkg::cmd_type q_ff [D];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic push, pop;

   assign in_ready  = (cnt_ff != (AW+1)'(D));
   assign out_valid = (cnt_ff != '0);
   assign out_cmd   = q_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= in_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(D-1)) ? '0 : wp_ff + 1'b1;
         if (pop)  rp_ff <= (rp_ff == AW'(D-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end
endmodule

// ===== hw/rtl/bblc_back.sv =====
// ----------------------------------------------------------------------------
// bblc_back: cache table and eviction sequencer
// Looks up, evicts oldest entries one per result, refuses oversized objects, and inserts at the front.
// ----------------------------------------------------------------------------
module bblc_back #(
   parameter int unsigned ENTRIES = bblc_pkg::ENTRIES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  bblc_pkg::cmd_type    cmd,
   input  logic [31:0]          capacity,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [63:0]          rsp_key,
   output logic [31:0]          rsp_size,
   output logic [31:0]          rsp_used,
   output logic                 rsp_last
);
   localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [63:0] key_ff  [ENTRIES];
   logic [31:0] size_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [IW-1:0] rank_ff [ENTRIES];
   logic [31:0] held_ff;

   bblc_pkg::back_state_type state_ff, state_in;
   bblc_pkg::cmd_type cur_ff;

   // result register
   logic        ovalid_ff;
   logic [1:0]  okind_ff;
   logic [63:0] okey_ff;
   logic [31:0] osize_ff, oused_ff;
   logic        olast_ff;

   // lookup / oldest search over the table (independent compares)
   logic [ENTRIES-1:0] hit_vec;
   logic               hit;
   logic [IW-1:0]      hit_idx, old_idx, free_idx;
   logic               full;
   logic [32:0]        need;

   always_comb begin
      hit = 1'b0; hit_idx = '0; old_idx = '0; free_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (key_ff[i] == cur_ff.key);
         if (hit_vec[i]) begin hit = 1'b1; hit_idx = IW'(i); end
         // valid ranks are distinct: the oldest holds count-1
         if (valid_ff[i] && (rank_ff[i] == IW'($countones(valid_ff) - 1)))
            old_idx = IW'(i);
      end
      for (int i = ENTRIES-1; i >= 0; i--)
         if (!valid_ff[i]) free_idx = IW'(i);
   end
   assign full = &valid_ff;
   assign need = {1'b0, held_ff} + {1'b0, cur_ff.size};

   logic out_free;
   assign out_free = !ovalid_ff || rsp_ready;
   assign cmd_ready = (state_ff == bblc_pkg::BK_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bblc_pkg::BK_IDLE: if (cmd_valid) state_in = bblc_pkg::BK_SCAN;
         bblc_pkg::BK_SCAN: state_in = bblc_pkg::BK_EMIT;
         bblc_pkg::BK_EMIT: begin
            if (out_free) begin
               if (hit || (cur_ff.size > capacity)) state_in = bblc_pkg::BK_IDLE;
               else if ((valid_ff != '0) && ((need > {1'b0, capacity}) || full))
                  state_in = bblc_pkg::BK_SCAN;
               else state_in = bblc_pkg::BK_IDLE;
            end
         end
         default: state_in = bblc_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == bblc_pkg::BK_IDLE && cmd_valid) cur_ff <= cmd;
      if (state_ff == bblc_pkg::BK_EMIT && out_free) begin
         if (hit) begin
            okind_ff <= bblc_pkg::KIND_HIT; okey_ff <= cur_ff.key;
            osize_ff <= size_ff[hit_idx]; oused_ff <= held_ff; olast_ff <= 1'b1;
         end else if (cur_ff.size > capacity) begin
            okind_ff <= bblc_pkg::KIND_TOO_BIG; okey_ff <= cur_ff.key;
            osize_ff <= cur_ff.size; oused_ff <= held_ff; olast_ff <= 1'b1;
         end else if ((valid_ff != '0) && ((need > {1'b0, capacity}) || full)) begin
            okind_ff <= bblc_pkg::KIND_EVICT; okey_ff <= key_ff[old_idx];
            osize_ff <= size_ff[old_idx]; oused_ff <= held_ff - size_ff[old_idx];
            olast_ff <= 1'b0;
         end else begin
            okind_ff <= bblc_pkg::KIND_INSERT; okey_ff <= cur_ff.key;
            osize_ff <= cur_ff.size; oused_ff <= need[31:0]; olast_ff <= 1'b1;
         end
      end
      if (state_ff == bblc_pkg::BK_EMIT && out_free && !hit
          && !(cur_ff.size > capacity)) begin
         if (!((valid_ff != '0) && ((need > {1'b0, capacity}) || full))) begin
            key_ff[free_idx]  <= cur_ff.key;
            size_ff[free_idx] <= cur_ff.size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bblc_pkg::BK_IDLE;
         valid_ff <= '0;
         held_ff  <= '0;
         ovalid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == bblc_pkg::BK_EMIT && out_free) ovalid_ff <= 1'b1;
         else if (rsp_ready) ovalid_ff <= 1'b0;
         if (state_ff == bblc_pkg::BK_EMIT && out_free) begin
            if (hit) begin
               for (int i = 0; i < ENTRIES; i++)
                  if (valid_ff[i] && rank_ff[i] < rank_ff[hit_idx])
                     rank_ff[i] <= rank_ff[i] + 1'b1;
               rank_ff[hit_idx] <= '0;
            end else if (cur_ff.size > capacity) begin
               // refuse, no change
            end else if ((valid_ff != '0) && ((need > {1'b0, capacity}) || full)) begin
               valid_ff[old_idx] <= 1'b0;
               held_ff <= held_ff - size_ff[old_idx];
            end else begin
               for (int i = 0; i < ENTRIES; i++)
                  if (valid_ff[i]) rank_ff[i] <= rank_ff[i] + 1'b1;
               valid_ff[free_idx] <= 1'b1;
               rank_ff[free_idx] <= '0;
               held_ff <= need[31:0];
            end
         end
      end
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_kind  = okind_ff;
   assign rsp_key   = okey_ff;
   assign rsp_size  = osize_ff;
   assign rsp_used  = oused_ff;
   assign rsp_last  = olast_ff;
endmodule

// ===== hw/rtl/byte_budget_lru_cache_core.sv =====
// Sequence: a request leaves the queue in the idle state, passes the scan state,
// and its first result is registered in the emit state, which waits while the
// result channel holds off. Each result after an eviction takes another scan and
// emit step; the next request is taken only in the idle state, after the last result.
// Reset: synchronous, clears the table valid bits, ranks, byte count and queue;
// capacity returns to 268435456.
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_core: size weighted LRU cache directory
// Request queue in front of the table sequencer, plus the capacity register.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache_core #(
   parameter int unsigned ENTRIES = bblc_pkg::ENTRIES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   bblc_req_if.sink   req,
   bblc_rsp_if.source rsp,
   bblc_csr_if.sink   csr
);
   logic [31:0] capacity_ff;
   bblc_pkg::cmd_type in_cmd, q_cmd;
   logic q_valid, q_ready;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) capacity_ff <= bblc_pkg::CAP_RESET;
      else if (csr.valid) capacity_ff <= csr.data;
   end

   assign in_cmd.key  = req.key;
   assign in_cmd.size = req.object_size;

   bblc_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_cmd(in_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
   );

   bblc_back #(.ENTRIES(ENTRIES)) u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .capacity(capacity_ff),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_kind(rsp.kind), .rsp_key(rsp.result_key), .rsp_size(rsp.entry_size),
      .rsp_used(rsp.used_bytes), .rsp_last(rsp.last)
   );
endmodule

// ===== hw/rtl/bblc_checker.sv =====
// ----------------------------------------------------------------------------
// bblc_checker: port level checks
// Watches the result channel of the cache core.
// ----------------------------------------------------------------------------
module bblc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic        rsp_last,
   input logic [63:0] rsp_result_key
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_key))
      else $error("result dropped while stalled");
   a_evict_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == bblc_pkg::KIND_EVICT |-> !rsp_last)
      else $error("eviction marked last");
   a_other_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != bblc_pkg::KIND_EVICT |-> rsp_last)
      else $error("final result not marked last");
endmodule

bind byte_budget_lru_cache_core bblc_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_kind(rsp.kind), .rsp_last(rsp.last), .rsp_result_key(rsp.result_key)
);
